@@ rtl/mdcc_pkg.sv @@
`timescale 1ns / 1ps
package mdcc_pkg;

  localparam int PIXEL_W  = 16;
  localparam int COUNT_W  = 17;
  localparam int ROW_LOG  = 5;
  localparam int ROW_W    = 1 << ROW_LOG;

  localparam logic [PIXEL_W-1:0] MASK_RESET = '1;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [ROW_LOG-1:0] bit_sel_t;

endpackage

@@ rtl/mdcc_if.sv @@
`timescale 1ns / 1ps
interface mdcc_in_if;
  logic                           valid;
  logic                           ready;
  logic [mdcc_pkg::PIXEL_W-1:0]   pixel;
  logic                           frame_end;

  modport source (output valid, output pixel, output frame_end, input ready);
  modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

interface mdcc_out_if;
  logic                           valid;
  logic                           ready;
  logic [mdcc_pkg::COUNT_W-1:0]   distinct_count;

  modport source (output valid, output distinct_count, input ready);
  modport sink   (input valid, input distinct_count, output ready);
endinterface

interface mdcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mdcc_pkg::PIXEL_W-1:0]   color_mask;

  modport source (output valid, output color_mask, input ready);
  modport sink   (input valid, input color_mask, output ready);
endinterface

@@ rtl/masked_distinct_color_counter.sv @@
`timescale 1ns / 1ps
// Counts the distinct masked colors of a pixel frame.
// in_ch carries one pixel per transfer plus a frame_end flag on the last
// pixel of a frame. Each pixel is ANDed with color_mask (written through
// cfg_ch, reset value all ones) and the low COLOR_BITS bits address a seen
// bitmap held in one synchronous RAM of 2^(COLOR_BITS-5) rows of 32 bits.
// The pixel's row is read when it is transferred and written back, with its
// bit set, from the s1 stage register; back-to-back hits on one row are forwarded.
// Within a frame one pixel is taken every cycle.
// For the frame_end pixel the count goes to the out_ch register when that
// pixel leaves the s1 stage; out_ch.distinct_count is then held until taken.
// After a frame_end pixel in_ch drops ready while it waits in s1 and during
// a map clear sweep of all 2^(COLOR_BITS-5) rows (2048 at COLOR_BITS = 16),
// one RAM row per cycle. The same sweep runs after reset (rst_n, synchronous, low).
// If the previous count still waits on a stalled out_ch when the next
// frame_end pixel completes, that pixel is held until the register frees.
// cfg_ch is always ready; write it only while the block is idle.
module masked_distinct_color_counter_core #(
  parameter int COLOR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mdcc_in_if.sink     in_ch,
  mdcc_out_if.source  out_ch,
  mdcc_cfg_if.sink    cfg_ch
);
  import mdcc_pkg::*;

  localparam int RA_W = COLOR_BITS - ROW_LOG;

  pixel_t            mask_r;
  pixel_t            masked;
  logic [RA_W-1:0]   in_row;
  bit_sel_t          in_bit;
  logic              accept;

  logic              s1_vld_r;
  logic              s1_last_r;
  logic [RA_W-1:0]   s1_row_r;
  bit_sel_t          s1_bit_r;
  logic              s1_fwd_r;
  row_t              s1_fwd_data_r;

  row_t              mem_rd;
  row_t              s1_cur;
  row_t              s1_new;
  logic              s1_hit;
  logic              s1_fire;
  logic              frame_done;
  logic              out_free;

  count_t            cnt_r;
  count_t            cnt_nxt;
  count_t            cnt_inc;
  logic              out_vld_r;
  count_t            out_cnt_r;

  logic              clr_active;
  logic [RA_W-1:0]   clr_row;
  logic              mem_we;
  logic [RA_W-1:0]   mem_waddr;
  row_t              mem_wdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_ch.valid) begin
      mask_r <= cfg_ch.color_mask;
    end
  end

  assign masked = in_ch.pixel & mask_r;
  assign in_row = masked[COLOR_BITS-1:ROW_LOG];
  assign in_bit = masked[ROW_LOG-1:0];

  assign in_ch.ready = !clr_active && !(s1_vld_r && s1_last_r);
  assign accept      = in_ch.valid && in_ch.ready;

  assign s1_cur     = s1_fwd_r ? s1_fwd_data_r : mem_rd;
  assign s1_hit     = s1_cur[s1_bit_r];
  assign s1_new     = s1_cur | (ROW_W'(1) << s1_bit_r);
  assign out_free   = !out_vld_r || out_ch.ready;
  assign s1_fire    = s1_vld_r && (!s1_last_r || out_free);
  assign frame_done = s1_fire && s1_last_r;
  assign cnt_inc    = cnt_r + COUNT_W'(!s1_hit);
  assign cnt_nxt    = frame_done ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  // forward the row being written when the next pixel reads the same row
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r     <= in_ch.frame_end;
      s1_row_r      <= in_row;
      s1_bit_r      <= in_bit;
      s1_fwd_r      <= s1_fire && (s1_row_r == in_row);
      s1_fwd_data_r <= s1_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (s1_fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (frame_done) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      out_cnt_r <= cnt_inc;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.distinct_count = out_cnt_r;

  assign mem_we    = clr_active || s1_fire;
  assign mem_waddr = clr_active ? clr_row : s1_row_r;
  assign mem_wdata = clr_active ? '0 : s1_new;

  mdcc_clear_seq #(
    .ADDR_W (RA_W)
  ) u_clear (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (frame_done),
    .active (clr_active),
    .row    (clr_row)
  );

  mdcc_seen_mem #(
    .ADDR_W (RA_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_row),
    .rdata (mem_rd)
  );

  a_clear_after_frame : assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> clr_active)
    else $error("clear sweep did not start after frame end");

  a_no_pixel_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    !(clr_active && s1_vld_r))
    else $error("pixel in flight during clear sweep");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (COUNT_W'(1) << COLOR_BITS))
    else $error("running count above map size");

  a_result_slot_free : assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> out_free)
    else $error("result register overwritten");

endmodule

@@ rtl/mdcc_seen_mem.sv @@
`timescale 1ns / 1ps
module mdcc_seen_mem #(
  parameter int ADDR_W = 11
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [mdcc_pkg::ROW_W-1:0]   wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [mdcc_pkg::ROW_W-1:0]   rdata
);
  import mdcc_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  row_t mem [DEPTH];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mdcc_clear_seq.sv @@
`timescale 1ns / 1ps
module mdcc_clear_seq #(
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              active,
  output logic [ADDR_W-1:0] row
);

  localparam logic [ADDR_W-1:0] LAST_ROW = '1;

  logic              active_r, active_nxt;
  logic [ADDR_W-1:0] row_r, row_nxt;

  always_comb begin
    active_nxt = active_r;
    row_nxt    = row_r;
    if (start) begin
      active_nxt = 1'b1;
      row_nxt    = '0;
    end else if (active_r) begin
      row_nxt = row_r + ADDR_W'(1);
      if (row_r == LAST_ROW) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      row_r    <= '0;
    end else begin
      active_r <= active_nxt;
      row_r    <= row_nxt;
    end
  end

  assign active = active_r;
  assign row    = row_r;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import mdcc_pkg::*;

  localparam int COLOR_BITS  = 16;
  localparam int MAP_DEPTH   = 1 << COLOR_BITS;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int RANDOM_ITEMS = 900;
  localparam int LONG_FRAME  = 512;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    pixel_t pixel;
    logic   frame_end;
  } pixel_item_t;

  logic clk;
  logic rst_n;

  mdcc_in_if  in_ch();
  mdcc_out_if out_ch();
  mdcc_cfg_if cfg_ch();

  masked_distinct_color_counter_core #(.COLOR_BITS(COLOR_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pixel_item_t pixel_q[$];
  count_t      expected_counts[$];

  bit          seen_colors [0:MAP_DEPTH-1];
  int unsigned touched_colors[$];
  count_t      distinct_so_far;
  pixel_t      mask_model;

  int          errors;
  int          cycle_count;
  int          burst_left;
  int          gap_left;
  int          ready_mode;
  int          ready_span;
  pixel_t      palette[8];

  localparam logic [15:0] STALL_PATTERN = 16'b1100_0000_1110_0101;
  localparam pixel_t MASK_LIST[7] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                                      16'h001F, 16'h8000, 16'h0001};

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // mark the masked color, close the frame on its last pixel
  function automatic void count_pixel(input pixel_t pixel, input logic last);
    int unsigned addr;
    addr = int'(pixel & mask_model) & (MAP_DEPTH - 1);
    if (!seen_colors[addr]) begin
      seen_colors[addr] = 1'b1;
      touched_colors.push_back(addr);
      distinct_so_far++;
    end
    if (last) begin
      expected_counts.push_back(distinct_so_far);
      foreach (touched_colors[i]) seen_colors[touched_colors[i]] = 1'b0;
      touched_colors.delete();
      distinct_so_far = '0;
    end
  endfunction

  function automatic pixel_t pick_pixel();
    case ($urandom_range(0, 3))
      0: return pixel_t'($urandom);
      1: return palette[$urandom_range(0, 7)];
      2: return palette[$urandom_range(0, 7)] ^ (pixel_t'(1) << $urandom_range(0, 15));
      default: return palette[$urandom_range(0, 1)];
    endcase
  endfunction

  task automatic push_pixel(input pixel_t pixel, input logic last);
    pixel_item_t item;
    item.pixel = pixel;
    item.frame_end = last;
    pixel_q.push_back(item);
  endtask

  // drain input, collect all counts, let the block finish, then wait for ready
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_ch.valid || expected_counts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_mask(input pixel_t value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.color_mask <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_item_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        item = pixel_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.pixel <= item.pixel;
        in_ch.frame_end <= item.frame_end;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_mode <= 0;
      ready_span <= 0;
    end else begin
      if (ready_span == 0) begin
        ready_mode <= $urandom_range(0, 2);
        ready_span <= $urandom_range(50, 400);
      end else begin
        ready_span <= ready_span - 1;
      end
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= STALL_PATTERN[cycle_count % 16];
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    count_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) count_pixel(in_ch.pixel, in_ch.frame_end);
      if (cfg_ch.valid && cfg_ch.ready) mask_model = cfg_ch.color_mask;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected count %0d", out_ch.distinct_count));
        end else begin
          want = expected_counts.pop_front();
          if (out_ch.distinct_count !== want)
            report_mismatch($sformatf("distinct_count %0d, want %0d",
                                      out_ch.distinct_count, want));
        end
      end
    end
  end

  initial begin
    int random_sent;
    int phase;
    int frames;
    int len;
    int split;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pixel = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.color_mask = '0;
    errors = 0;
    cycle_count = 0;
    distinct_so_far = '0;
    mask_model = MASK_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // reset mask keeps every bit
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h1234, 1'b1);
    push_pixel(16'hAAAA, 1'b1);
    push_pixel(16'h5555, 1'b0);
    push_pixel(16'h5555, 1'b1);

    wait_idle();
    write_mask(16'h0000);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h1234, 1'b1);

    wait_idle();
    write_mask(16'hF800);
    push_pixel(16'hF800, 1'b0);
    push_pixel(16'hF81F, 1'b0);
    push_pixel(16'h07E0, 1'b0);
    push_pixel(16'h001F, 1'b1);

    // change the mask in the middle of a frame
    wait_idle();
    write_mask(16'hFFFF);
    push_pixel(16'h0001, 1'b0);
    push_pixel(16'h0002, 1'b0);
    wait_idle();
    write_mask(16'h0003);
    push_pixel(16'h0005, 1'b0);
    push_pixel(16'h0007, 1'b0);
    push_pixel(16'h0001, 1'b1);

    // long frame of distinct colors across many rows
    wait_idle();
    write_mask(16'hFFFF);
    for (int i = 0; i < LONG_FRAME; i++)
      push_pixel(pixel_t'(i) ^ 16'h5A5A, i == LONG_FRAME - 1);

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      write_mask(phase < 7 ? MASK_LIST[phase] : pixel_t'($urandom));
      phase++;
      foreach (palette[i]) palette[i] = pixel_t'($urandom);
      frames = $urandom_range(2, 8);
      for (int f = 0; f < frames; f++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        split = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : 0;
        for (int k = 0; k < len; k++) begin
          if (k == split && k > 0) begin
            wait_idle();
            write_mask(pixel_t'($urandom));
          end
          push_pixel(pick_pixel(), k == len - 1);
          random_sent++;
        end
      end
    end

    while (pixel_q.size() != 0 || in_ch.valid || expected_counts.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
